// ===== hw/rtl/mbss_pkg.sv =====
// Shared types, sizes and register codes for the masked byte signature scanner.
// No dependencies; every other file of the block imports this package.
package mbss_pkg;

    localparam int WINDOW_BYTES  = 32;
    localparam int POSITION_BITS = 32;
    localparam int PAT_BYTES     = 32;
    localparam int OFFSET_BITS   = 34;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int WILD_W        = 32;
    localparam int RAW_LEN_W     = 6;
    localparam int DIST_W        = 5;
    localparam int DISP_W        = 32;

    localparam int MATCH_BYTES = (PAT_BYTES < WINDOW_BYTES) ? PAT_BYTES : WINDOW_BYTES;
    localparam int LEN_W       = $clog2(MATCH_BYTES + 1);
    localparam int WIN_W       = WINDOW_BYTES * 8;
    localparam int SUM_W       = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_WILD      = 3'd4,
        CFG_LEN       = 3'd5,
        CFG_DIST      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_WAIT   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [WILD_W-1:0]      wild;
        logic [LEN_W-1:0]       len;
        logic [DIST_W-1:0]      distance;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       range_end;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [DISP_W-1:0] disp_now;
        logic [DISP_W-1:0] disp_wait;
    } t_win;

    function automatic logic [DISP_W-1:0] bswap32(input logic [DISP_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== hw/rtl/mbss_cfg_regs.sv =====
// Configuration register file: pattern bytes, wildcard mask, length, distance.
// Depends on mbss_pkg; presents the clamped settings as one struct.
module mbss_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbss_pkg::t_cfg                  o_cfg
);
    import mbss_pkg::*;

    logic [63:0]          r_pat_0;
    logic [63:0]          r_pat_1;
    logic [63:0]          r_pat_2;
    logic [63:0]          r_pat_3;
    logic [WILD_W-1:0]    r_wild;
    logic [RAW_LEN_W-1:0] r_len;
    logic [DIST_W-1:0]    r_dist;
    logic [LEN_W-1:0]     eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_0 <= '0;
            r_pat_1 <= '0;
            r_pat_2 <= '0;
            r_pat_3 <= '0;
            r_wild  <= '0;
            r_len   <= RAW_LEN_W'(1);
            r_dist  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAT_0_7:   r_pat_0 <= i_cfg_data[63:0];
                CFG_PAT_8_15:  r_pat_1 <= i_cfg_data[63:0];
                CFG_PAT_16_23: r_pat_2 <= i_cfg_data[63:0];
                CFG_PAT_24_31: r_pat_3 <= i_cfg_data[63:0];
                CFG_WILD:      r_wild  <= i_cfg_data[WILD_W-1:0];
                CFG_LEN:       r_len   <= i_cfg_data[RAW_LEN_W-1:0];
                CFG_DIST:      r_dist  <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > RAW_LEN_W'(MATCH_BYTES)) begin
            eff_len = LEN_W'(MATCH_BYTES);
        end else begin
            eff_len = LEN_W'(r_len);
        end
    end

    assign o_cfg.pattern  = {r_pat_3, r_pat_2, r_pat_1, r_pat_0};
    assign o_cfg.wild     = r_wild;
    assign o_cfg.len      = eff_len;
    assign o_cfg.distance = r_dist;

endmodule

// ===== hw/rtl/mbss_in_stage.sv =====
// Input register of the scanner: holds one byte transfer until the core takes it.
// Depends on mbss_pkg for the item struct.
module mbss_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_range_end,
    input  logic            i_adv,
    output logic            o_stall,
    output mbss_pkg::t_item o_item
);
    import mbss_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       accept;

    assign o_stall = r_valid && !i_adv;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_last <= i_range_end;
        end
    end

    assign o_item.valid     = r_valid;
    assign o_item.data_byte = r_byte;
    assign o_item.range_end = r_last;

endmodule

// ===== hw/rtl/mbss_window.sv =====
// Sliding byte window with masked pattern compare and displacement extraction.
// Depends on mbss_pkg; results refer to the window after the pending byte shifts in.
module mbss_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [7:0]     i_byte,
    input  mbss_pkg::t_cfg i_cfg,
    output mbss_pkg::t_win o_win
);
    import mbss_pkg::*;

    logic [WIN_W-1:0]         r_win;
    logic [WIN_W-1:0]         win_new;
    logic [MATCH_BYTES*8-1:0] rev_pat;
    logic [MATCH_BYTES-1:0]   rev_wild;
    logic [MATCH_BYTES*8-1:0] aligned_pat;
    logic [MATCH_BYTES-1:0]   aligned_wild;
    logic [LEN_W-1:0]         shift;
    logic [MATCH_BYTES-1:0]   ok;
    logic [6:0]               off;
    logic [WIN_W-1:0]         slice;

    assign win_new = {r_win[WIN_W-9:0], i_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_adv) begin
            r_win <= win_new;
        end
    end

    // reverse the pattern, then shift it so pattern byte len-1 lines up with the newest byte
    always_comb begin
        for (int k = 0; k < MATCH_BYTES; k++) begin
            rev_pat[8*k +: 8] = i_cfg.pattern[8*(MATCH_BYTES-1-k) +: 8];
            rev_wild[k]       = i_cfg.wild[MATCH_BYTES-1-k];
        end
    end

    assign shift        = LEN_W'(MATCH_BYTES) - i_cfg.len;
    assign aligned_pat  = rev_pat >> {shift, 3'b000};
    assign aligned_wild = rev_wild >> shift;

    always_comb begin
        for (int j = 0; j < MATCH_BYTES; j++) begin
            ok[j] = (j >= int'(i_cfg.len)) || aligned_wild[j] ||
                    (win_new[8*j +: 8] == aligned_pat[8*j +: 8]);
        end
    end

    assign off   = 7'(i_cfg.len) - 7'(i_cfg.distance) - 7'd4;
    assign slice = win_new >> {off, 3'b000};

    assign o_win.hit       = &ok;
    assign o_win.disp_now  = bswap32(slice[DISP_W-1:0]);
    assign o_win.disp_wait = bswap32(win_new[DISP_W-1:0]);

endmodule

// ===== hw/rtl/mbss_scan_ctrl.sv =====
// Scan sequencer: position counter, phase machine, offset adder and result register.
// Depends on mbss_pkg; takes the window compare results and the current settings.
module mbss_scan_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mbss_pkg::t_item                        i_item,
    input  mbss_pkg::t_win                         i_win,
    input  mbss_pkg::t_cfg                         i_cfg,
    input  logic                                   i_stall,
    output logic                                   o_adv,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic                                   o_resolved,
    output logic signed [mbss_pkg::OFFSET_BITS-1:0] o_result_offset
);
    import mbss_pkg::*;

    t_phase                   r_phase;
    t_phase                   n_phase;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] r_mstart;
    logic [POSITION_BITS-1:0] n_mstart;
    logic                     r_out_valid;
    logic                     r_found;
    logic                     r_resolved;
    logic [OFFSET_BITS-1:0]   r_offset;

    logic                     emit;
    logic                     e_found;
    logic                     e_resolved;
    logic [OFFSET_BITS-1:0]   e_offset;

    logic [POSITION_BITS:0]   pos_p1;
    logic [POSITION_BITS-1:0] mstart_new;
    logic                     hit;
    logic                     room;
    logic [POSITION_BITS:0]   need;
    logic                     at_need;
    logic                     waiting;
    logic signed [7:0]        k;
    logic [POSITION_BITS-1:0] base;
    logic [DISP_W-1:0]        disp;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W-1:0]         bare_new;
    logic [SUM_W-1:0]         bare_old;

    assign o_adv = i_item.valid && (!r_out_valid || !i_stall);

    assign pos_p1     = {1'b0, r_pos} + (POSITION_BITS+1)'(1);
    assign mstart_new = POSITION_BITS'(pos_p1 - (POSITION_BITS+1)'(i_cfg.len));
    assign hit        = (r_pos >= POSITION_BITS'(i_cfg.len) - POSITION_BITS'(1)) && i_win.hit;
    assign room       = (7'(i_cfg.distance) + 7'd4) <= 7'(i_cfg.len);
    assign need       = {1'b0, r_mstart} + (POSITION_BITS+1)'(i_cfg.distance)
                        + (POSITION_BITS+1)'(3);
    assign at_need    = ({1'b0, r_pos} == need);

    // target = start + distance + 4 + signed displacement, start = pos + 1 - len on a fresh hit
    assign waiting = (r_phase == PH_WAIT);
    assign k       = waiting ? (8'(i_cfg.distance) + 8'sd4)
                             : (8'(i_cfg.distance) + 8'sd5 - 8'(i_cfg.len));
    assign base    = waiting ? r_mstart : r_pos;
    assign disp    = waiting ? i_win.disp_wait : i_win.disp_now;
    assign sum     = SUM_W'(base) + {{(SUM_W-8){k[7]}}, k}
                     + {{(SUM_W-DISP_W){disp[DISP_W-1]}}, disp};

    assign bare_new = SUM_W'(mstart_new);
    assign bare_old = SUM_W'(r_mstart);

    always_comb begin
        n_phase    = r_phase;
        n_mstart   = r_mstart;
        n_pos      = r_pos;
        emit       = 1'b0;
        e_found    = 1'b0;
        e_resolved = 1'b0;
        e_offset   = '0;
        unique case (r_phase)
            PH_SEARCH: begin
                if (hit) begin
                    n_mstart = mstart_new;
                    if (room) begin
                        emit       = 1'b1;
                        e_found    = 1'b1;
                        e_resolved = 1'b1;
                        e_offset   = sum[OFFSET_BITS-1:0];
                        n_phase    = PH_DONE;
                    end else if (i_item.range_end) begin
                        emit     = 1'b1;
                        e_found  = 1'b1;
                        e_offset = bare_new[OFFSET_BITS-1:0];
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end else if (i_item.range_end) begin
                    emit = 1'b1;
                end
            end
            PH_WAIT: begin
                if (at_need) begin
                    emit       = 1'b1;
                    e_found    = 1'b1;
                    e_resolved = 1'b1;
                    e_offset   = sum[OFFSET_BITS-1:0];
                    n_phase    = PH_DONE;
                end else if (i_item.range_end) begin
                    emit     = 1'b1;
                    e_found  = 1'b1;
                    e_offset = bare_old[OFFSET_BITS-1:0];
                    n_phase  = PH_DONE;
                end
            end
            default: ;
        endcase
        if (i_item.range_end) begin
            n_phase  = PH_SEARCH;
            n_pos    = '0;
            n_mstart = '0;
        end else if (r_pos != {POSITION_BITS{1'b1}}) begin
            n_pos = r_pos + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_pos    <= '0;
            r_mstart <= '0;
        end else if (o_adv) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_mstart <= n_mstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && emit) begin
            r_found    <= e_found;
            r_resolved <= e_resolved;
            r_offset   <= e_offset;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_resolved      = r_resolved;
    assign o_result_offset = r_offset;

endmodule

// ===== hw/rtl/masked_byte_signature_scanner.sv =====
// Top level of the masked byte signature scanner.
// Depends on mbss_pkg, mbss_cfg_regs, mbss_in_stage, mbss_window and mbss_scan_ctrl.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ----------------------------------------------
//   in       i_valid / o_stall   i_data_byte[7:0], i_range_end
//   out      o_valid / i_stall   o_found, o_resolved, o_result_offset[33:0]
//   config   i_cfg_we            i_cfg_idx[2:0], i_cfg_data[63:0]
//
// One byte per cycle sustained while the output is not held; a transfer lands in the
// input register, and the window compare plus offset adder fill the result register
// when that byte advances out of the input register.
// Synchronous active-low reset clears window, position, phase and both valids.
// A held output stalls the input register, which then raises o_stall.
module masked_byte_signature_scanner (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [7:0]                              i_data_byte,
    input  logic                                    i_range_end,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_found,
    output logic                                    o_resolved,
    output logic signed [mbss_pkg::OFFSET_BITS-1:0] o_result_offset,
    input  logic                                    i_cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import mbss_pkg::*;

    t_cfg  cfg;
    t_item item;
    t_win  win;
    logic  adv;

    mbss_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mbss_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_range_end (i_range_end),
        .i_adv       (adv),
        .o_stall     (o_stall),
        .o_item      (item)
    );

    mbss_window u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (item.data_byte),
        .i_cfg   (cfg),
        .o_win   (win)
    );

    mbss_scan_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item),
        .i_win           (win),
        .i_cfg           (cfg),
        .i_stall         (i_stall),
        .o_adv           (adv),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_resolved      (o_resolved),
        .o_result_offset (o_result_offset)
    );

endmodule

// ===== hw/rtl/mbss_checker.sv =====
// Port-level checks for the masked byte signature scanner, bound to the top level.
// Depends on mbss_pkg for the offset width.
module mbss_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic                                    o_found,
    input logic                                    o_resolved,
    input logic signed [mbss_pkg::OFFSET_BITS-1:0] o_result_offset
);
    import mbss_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_resolved)
                               && $stable(o_result_offset))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_resolved_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_resolved |-> o_found)
        else $error("resolved result without a match");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> !o_resolved && (o_result_offset == '0))
        else $error("not-found result carries an offset");

    a_bare_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found && !o_resolved |->
            (o_result_offset[OFFSET_BITS-1:POSITION_BITS] == '0))
        else $error("bare match offset beyond the position range");

endmodule

bind masked_byte_signature_scanner mbss_checker u_mbss_checker (.*);
